// ===== rtl/u64_to_decimal_ascii_core_defines.svh =====
// u64_to_decimal_ascii_core_defines.svh: assertion macros for the decimal ascii converter
// no dependencies; taken in by `include where assertions are written
`ifndef U64_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define U64_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// checked on every clock edge outside reset
`define U2DA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define U2DA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/u2da_pkg.sv =====
// u2da_pkg: types, constants and codes of the decimal ascii converter
// no dependencies; used by the bcd unit, the sequencer and the core
`default_nettype none

package u2da_pkg;

   localparam int VALUE_BITS_DEF = 64;
   localparam int MAX_DIGITS_DEF = 20;
   localparam int BCD_DIGITS     = 20;
   localparam int NIBBLE_W       = 4;
   localparam int IN_W           = 64;
   localparam int LEN_W          = 8;
   localparam int CHAR_W         = 6;
   localparam int COUNT_W        = 5;

   // ascii '0' is 6'b11_0000, so a digit only fills the low nibble
   localparam logic [1:0]        ASCII_DIGIT_HI = 2'b11;
   localparam logic [CHAR_W-1:0] CHAR_NUL       = '0;

   typedef struct packed {
      logic [IN_W-1:0]  value;
      logic [LEN_W-1:0] buffer_length;
   } req_word_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  character;
      logic [COUNT_W-1:0] digit_count;
      logic               overflow_error;
      logic               last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_DABBLE,
      OP_SHIFT
   } op_type;

   typedef struct packed {
      op_type op;
   } unit_ctrl_type;

   typedef struct packed {
      logic [NIBBLE_W-1:0] top_digit;
      logic                top_zero;
      logic                bits_done;
   } unit_status_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CONV  = 6'b000010,
      S_SCAN  = 6'b000100,
      S_DIGIT = 6'b001000,
      S_TERM  = 6'b010000,
      S_ERR   = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/u2da_stream_if.sv =====
// u2da_stream_if: valid/ready channel carrying one word of a given payload type
// depends on nothing; payload types come from u2da_pkg at the point of use
`default_nettype none

interface u2da_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/u2da_bcd_unit.sv =====
// u2da_bcd_unit: shared shift-add-3 unit, binary to bcd one bit a cycle, then digit shifting
// depends on u2da_pkg
`default_nettype none

module u2da_bcd_unit #(
   parameter int VALUE_BITS = u2da_pkg::VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire u2da_pkg::unit_ctrl_type      ctrl,
   input  wire logic [u2da_pkg::IN_W-1:0]    load_value,
   output      u2da_pkg::unit_status_type    status
);

   localparam int BCD_W = u2da_pkg::BCD_DIGITS * u2da_pkg::NIBBLE_W;
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int NW    = u2da_pkg::NIBBLE_W;

   logic [BCD_W-1:0]      bcd_ff, bcd_in, adj;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [CNT_W-1:0]      bits_ff, bits_in;

   // add 3 to every digit of 5 or more before the doubling shift
   always_comb begin
      for (int i = 0; i < u2da_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[i*NW +: NW] >= NW'(5)) begin
            adj[i*NW +: NW] = bcd_ff[i*NW +: NW] + NW'(3);
         end else begin
            adj[i*NW +: NW] = bcd_ff[i*NW +: NW];
         end
      end
   end

   always_comb begin
      bcd_in   = bcd_ff;
      value_in = value_ff;
      bits_in  = bits_ff;
      case (ctrl.op)
         u2da_pkg::OP_LOAD: begin
            bcd_in   = '0;
            value_in = load_value[VALUE_BITS-1:0];
            bits_in  = CNT_W'(VALUE_BITS);
         end
         u2da_pkg::OP_DABBLE: begin
            bcd_in   = {adj[BCD_W-2:0], value_ff[VALUE_BITS-1]};
            value_in = value_ff << 1;
            bits_in  = bits_ff - CNT_W'(1);
         end
         u2da_pkg::OP_SHIFT: begin
            bcd_in = {bcd_ff[BCD_W-NW-1:0], {NW{1'b0}}};
         end
         default: begin
            bcd_in = bcd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bcd_ff   <= bcd_in;
      value_ff <= value_in;
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

   assign status.top_digit = bcd_ff[BCD_W-1 -: NW];
   assign status.top_zero  = (bcd_ff[BCD_W-1 -: NW] == '0);
   assign status.bits_done = (bits_ff == CNT_W'(1));

endmodule

`default_nettype wire

// ===== rtl/u2da_ctrl.sv =====
// u2da_ctrl: sequencer for load, conversion, leading zero scan and word output
// depends on u2da_pkg and u64_to_decimal_ascii_core_defines.svh
`default_nettype none
`include "u64_to_decimal_ascii_core_defines.svh"

module u2da_ctrl #(
   parameter int MAX_DIGITS = u2da_pkg::MAX_DIGITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [u2da_pkg::LEN_W-1:0]     buffer_length,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      u2da_pkg::rsp_word_type         rsp_word,
   output      u2da_pkg::unit_ctrl_type        unit_ctrl,
   input  wire u2da_pkg::unit_status_type      status
);

   localparam int CW = u2da_pkg::COUNT_W;

   u2da_pkg::state_type               state_ff, state_in;
   logic [u2da_pkg::LEN_W-1:0]        len_ff, len_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     remain_ff, remain_in;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      unit_ctrl.op = u2da_pkg::OP_HOLD;
      case (state_ff)
         u2da_pkg::S_IDLE: begin
            if (req_valid) begin
               unit_ctrl.op = u2da_pkg::OP_LOAD;
               len_in       = buffer_length;
               state_in     = u2da_pkg::S_CONV;
            end
         end
         u2da_pkg::S_CONV: begin
            unit_ctrl.op = u2da_pkg::OP_DABBLE;
            if (status.bits_done) begin
               count_in = CW'(u2da_pkg::BCD_DIGITS);
               state_in = u2da_pkg::S_SCAN;
            end
         end
         u2da_pkg::S_SCAN: begin
            // strip leading zero digits, keeping at least one
            if (status.top_zero && count_ff > CW'(1)) begin
               unit_ctrl.op = u2da_pkg::OP_SHIFT;
               count_in     = count_ff - CW'(1);
            end else if (count_ff > CW'(MAX_DIGITS) ||
                         u2da_pkg::LEN_W'(count_ff) >= len_ff) begin
               state_in = u2da_pkg::S_ERR;
            end else begin
               remain_in = count_ff;
               state_in  = u2da_pkg::S_DIGIT;
            end
         end
         u2da_pkg::S_DIGIT: begin
            if (rsp_ready) begin
               unit_ctrl.op = u2da_pkg::OP_SHIFT;
               remain_in    = remain_ff - CW'(1);
               if (remain_ff == CW'(1)) begin
                  state_in = u2da_pkg::S_TERM;
               end
            end
         end
         u2da_pkg::S_TERM, u2da_pkg::S_ERR: begin
            if (rsp_ready) begin
               state_in = u2da_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = u2da_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      if (reset) begin
         state_ff  <= u2da_pkg::S_IDLE;
         count_ff  <= '0;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
      end
   end

   assign req_ready = (state_ff == u2da_pkg::S_IDLE);
   assign rsp_valid = (state_ff == u2da_pkg::S_DIGIT) || (state_ff == u2da_pkg::S_TERM) ||
                      (state_ff == u2da_pkg::S_ERR);

   assign rsp_word.character      = (state_ff == u2da_pkg::S_DIGIT) ?
                                    {u2da_pkg::ASCII_DIGIT_HI, status.top_digit} :
                                    u2da_pkg::CHAR_NUL;
   assign rsp_word.digit_count    = (state_ff == u2da_pkg::S_ERR) ? '0 : count_ff;
   assign rsp_word.overflow_error = (state_ff == u2da_pkg::S_ERR);
   assign rsp_word.last           = (state_ff == u2da_pkg::S_TERM) ||
                                    (state_ff == u2da_pkg::S_ERR);

   `U2DA_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == u2da_pkg::S_IDLE), "not idle after reset")
   `U2DA_ASSERT(a_busy_excl, rsp_valid |-> !req_ready, "word offered while taking input")
   `U2DA_ASSERT(a_load_conv, (req_valid && req_ready) |=> (state_ff == u2da_pkg::S_CONV), "no conversion after load")
   `U2DA_ASSERT(a_digit_bcd, (state_ff == u2da_pkg::S_DIGIT) |-> (status.top_digit <= 4'd9), "bad bcd digit")
   `U2DA_ASSERT(a_digit_rem, (state_ff == u2da_pkg::S_DIGIT) |-> (remain_ff != '0 && remain_ff <= count_ff), "digit count mismatch")

endmodule

`default_nettype wire

// ===== rtl/u64_to_decimal_ascii_core.sv =====
// sequence: accept, then shift-add-3 over every value bit in the shared bcd unit, then a
// leading zero scan, then one word per digit and one terminator word
// a new value is taken only once the last word of the previous one has been accepted
// an overflow gives one error word in place of the digits and terminator
// synchronous active-high reset returns the sequencer to idle; no state kept between values
`default_nettype none

module u64_to_decimal_ascii_core #(
   parameter int VALUE_BITS = u2da_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = u2da_pkg::MAX_DIGITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   u2da_stream_if.sink     req_chan,
   u2da_stream_if.source   rsp_chan
);

   u2da_pkg::unit_ctrl_type   unit_ctrl;
   u2da_pkg::unit_status_type unit_status;
   u2da_pkg::rsp_word_type    rsp_word;
   u2da_pkg::req_word_type    req_word;

   assign req_word         = req_chan.payload;
   assign rsp_chan.payload = rsp_word;

   u2da_bcd_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_bcd_unit (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (unit_ctrl),
      .load_value (req_word.value),
      .status     (unit_status)
   );

   u2da_ctrl #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .buffer_length (req_word.buffer_length),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_word      (rsp_word),
      .unit_ctrl     (unit_ctrl),
      .status        (unit_status)
   );

endmodule

`default_nettype wire
